/* hw/rtl/substring_occurrence_marker_macros.svh */
// Assertion macros for the substring occurrence marker checker.
// Included by the checker file only; no other dependencies.
`ifndef SUBSTRING_OCCURRENCE_MARKER_MACROS_SVH
`define SUBSTRING_OCCURRENCE_MARKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SOM_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("substring_occurrence_marker: implication check failed");

// Next-cycle implication, disabled during reset.
`define SOM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("substring_occurrence_marker: next-cycle check failed");

`endif

/* hw/rtl/som_pkg.sv */
// Shared types and constants for the substring occurrence marker.
// Used by som_ctrl, som_datapath, the top level, som_checker and the testbench; no dependencies.
package som_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LengthW = 6;
  localparam int unsigned IndexW  = 5;
  localparam int unsigned PosOutW = 16;

  // request kinds on the input channel
  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_TEXT    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_EMIT
  } som_state_e;

  // controller -> datapath
  typedef struct packed {
    logic ready;  // input request can be taken
    logic align;  // capture aligned window for the oldest pending start
    logic emit;   // load one flag into the output register
    logic clr;    // end of text: clear counters and window
  } som_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pend_ge_len;  // pending starts >= effective pattern length
    logic pend_one;     // exactly one start pending
    logic text_end;     // current text byte closed the text
    logic out_free;     // output register can take a flag this cycle
  } som_stat_t;

endpackage

/* hw/rtl/som_ctrl.sv */
// Sequencer for the substring occurrence marker.
// Depends on som_pkg (state enum, command and status structs).
module som_ctrl import som_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      req_type_i,
  input  som_stat_t stat_i,
  output som_cmd_t  cmd_o
);

  som_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.ready = 1'b1;
        if (in_valid_i && (req_type_i == REQ_TEXT)) begin
          state_d = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        // a flag is due when enough bytes are in, or when the text ends
        if (stat_i.pend_ge_len || stat_i.text_end) begin
          cmd_o.align = 1'b1;
          state_d     = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.text_end && !stat_i.pend_one) begin
            state_d = ST_ALIGN;
          end else begin
            cmd_o.clr = stat_i.text_end;
            state_d   = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/som_datapath.sv */
// Datapath: pattern store, text window, position counters, aligner,
// byte compare cells and the output register. Depends on som_pkg.
module som_datapath import som_pkg::*; #(
  parameter int unsigned MAX_PATTERN   = 32,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_accept_i,
  input  logic               req_type_i,
  input  logic [IndexW-1:0]  pattern_index_i,
  input  logic [ByteW-1:0]   data_byte_i,
  input  logic               text_end_i,
  input  logic               cfg_we_i,
  input  logic [LengthW-1:0] cfg_wdata_i,
  input  som_cmd_t           cmd_i,
  output som_stat_t          stat_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic               match_flag_o,
  output logic [PosOutW-1:0] start_position_o,
  output logic               last_flag_o
);

  localparam int unsigned AgeW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned WinW = MAX_PATTERN * ByteW;

  logic [ByteW-1:0]         pat_q [MAX_PATTERN];
  logic [WinW-1:0]          win_q, win_d;
  logic [WinW-1:0]          rev;
  logic [WinW-1:0]          algn_q, algn_d;
  logic                     cmp_en_q;
  logic                     end_q;
  logic [LengthW-1:0]       len_q;
  logic [LenW-1:0]          len_eff;
  logic [POSITION_BITS-1:0] seen_q, seen_d;
  logic [POSITION_BITS-1:0] given_q, given_d;
  logic [POSITION_BITS-1:0] pend;
  logic [AgeW-1:0]          age;
  logic [AgeW-1:0]          sh;
  logic                     flag;
  logic                     text_acc;
  logic                     out_valid_q;
  logic                     flag_q;
  logic [PosOutW-1:0]       pos_q;
  logic                     last_q;

  assign text_acc = in_accept_i && (req_type_i == REQ_TEXT);

  // lengths beyond the store saturate
  always_comb begin
    if (int'(len_q) > MAX_PATTERN) begin
      len_eff = LenW'(MAX_PATTERN);
    end else begin
      len_eff = LenW'(len_q);
    end
  end

  assign pend = seen_q - given_q;
  assign age  = AgeW'(pend - POSITION_BITS'(1));
  assign sh   = AgeW'(MAX_PATTERN - 1) - age;

  // oldest entry first, then shift so cell i sees the byte i after the start
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      rev[k*ByteW +: ByteW] = win_q[(MAX_PATTERN-1-k)*ByteW +: ByteW];
    end
    algn_d = rev >> {sh, 3'b000};
  end

  // compare cells; cells past the pattern length always pass
  always_comb begin
    flag = cmp_en_q;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((i < int'(len_eff)) && (pat_q[i] != algn_q[i*ByteW +: ByteW])) begin
        flag = 1'b0;
      end
    end
  end

  always_comb begin
    win_d   = win_q;
    seen_d  = seen_q;
    given_d = given_q;
    if (cmd_i.clr) begin
      win_d   = '0;
      seen_d  = '0;
      given_d = '0;
    end else begin
      if (text_acc) begin
        win_d  = (win_q << ByteW) | WinW'(data_byte_i);
        seen_d = seen_q + POSITION_BITS'(1);
      end
      if (cmd_i.emit) begin
        given_d = given_q + POSITION_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      seen_q      <= '0;
      given_q     <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      win_q   <= win_d;
      seen_q  <= seen_d;
      given_q <= given_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pattern store: no reset, writes past the store are dropped
  always_ff @(posedge clk_i) begin
    if (in_accept_i && (req_type_i == REQ_PATTERN)) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (int'(pattern_index_i) == i) begin
          pat_q[i] <= data_byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_acc) begin
      end_q <= text_end_i;
    end
    if (cmd_i.align) begin
      algn_q   <= algn_d;
      cmp_en_q <= stat_o.pend_ge_len;
    end
    if (cmd_i.emit) begin
      flag_q <= flag;
      pos_q  <= PosOutW'(given_q);
      last_q <= end_q && stat_o.pend_one;
    end
  end

  assign stat_o.pend_ge_len = pend >= POSITION_BITS'(len_eff);
  assign stat_o.pend_one    = pend == POSITION_BITS'(1);
  assign stat_o.text_end    = end_q;
  assign stat_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign match_flag_o     = flag_q;
  assign start_position_o = pos_q;
  assign last_flag_o      = last_q;

endmodule

/* hw/rtl/substring_occurrence_marker.sv */
// Sequence: a text byte is taken in idle, then the align state captures the window when a flag is due
//   and emit loads the flag into the output register, waiting while the output stalls. Pattern writes
//   stay in idle; no new request is taken until the controller is back in idle, and the end-of-text
//   flush repeats align and emit once per trailing start, oldest first.
// Reset: state, counters, text window, pattern length and output valid clear;
//   the pattern store holds garbage until written.
module substring_occurrence_marker import som_pkg::*; #(
  parameter int unsigned MAX_PATTERN   = 32,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration: pattern length
  input  logic               cfg_we_i,
  input  logic [LengthW-1:0] cfg_wdata_i,
  // input requests
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [IndexW-1:0]  pattern_index_i,
  input  logic [ByteW-1:0]   data_byte_i,
  input  logic               text_end_i,
  // flag results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               match_flag_o,
  output logic [PosOutW-1:0] start_position_o,
  output logic               last_flag_o
);

  // The controller steps through accept, align and emit. The datapath keeps
  // the text window as a shift line (newest byte in entry 0) and the pattern
  // store in flops. For the oldest pending start, the aligner reverses and shifts the
  // window so that compare cell i sees the text byte at offset i; all cells
  // compare in parallel and AND into one flag. At text end the same two
  // steps repeat once per remaining pending start, oldest first.

  som_cmd_t  cmd;
  som_stat_t stat;
  logic      in_accept;

  assign in_stall_o = !cmd.ready;
  assign in_accept  = in_valid_i && cmd.ready;

  som_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  som_datapath #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_accept_i      (in_accept),
    .req_type_i       (req_type_i),
    .pattern_index_i  (pattern_index_i),
    .data_byte_i      (data_byte_i),
    .text_end_i       (text_end_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .match_flag_o     (match_flag_o),
    .start_position_o (start_position_o),
    .last_flag_o      (last_flag_o)
  );

endmodule

/* hw/rtl/som_checker.sv */
// Port-level checks for substring_occurrence_marker, bound to the top level.
// Depends on som_pkg and substring_occurrence_marker_macros.svh.
`include "substring_occurrence_marker_macros.svh"

module som_checker import som_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               req_type_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               match_flag_o,
  input logic [PosOutW-1:0] start_position_o,
  input logic               last_flag_o
);

  logic                 last_seen_q;
  logic                 out_held;
  logic                 text_taken;
  logic                 first_out;
  logic [PosOutW+1:0]   out_bits;

  assign out_held   = out_valid_o && out_stall_i;
  assign text_taken = in_valid_i && !in_stall_o && (req_type_i == REQ_TEXT);
  assign first_out  = out_valid_o && last_seen_q;
  assign out_bits   = {match_flag_o, start_position_o, last_flag_o};

  // a new text starts after reset and after every last flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seen_q <= 1'b1;
    end else if (out_valid_o && !out_stall_i) begin
      last_seen_q <= last_flag_o;
    end
  end

  `SOM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_bits))
  `SOM_ASSERT_NEXT(a_text_busy, clk_i, rst_ni, text_taken, in_stall_o)
  `SOM_ASSERT_IMPL(a_first_pos_zero, clk_i, rst_ni, first_out, start_position_o == '0)

endmodule

bind substring_occurrence_marker som_checker u_som_checker (.*);

/* verif/testbench.sv */
// Self-checking bench for substring_occurrence_marker: streams pattern and text requests,
// predicts every match flag in SystemVerilog and checks each flag in arrival order.
// Depends on som_pkg and the substring_occurrence_marker RTL only.
module testbench import som_pkg::*;;

  localparam int MaxPat        = 32;    // pattern store depth of the block
  localparam int RandItems     = 290;   // random requests before the stimulus stops
  localparam int SettleCycles  = 8;     // block may still be busy after the last flag
  localparam int HoldCycles    = 200;   // one long output hold-off
  localparam int WatchdogLimit = 2000;  // cycles with no transfer at all

  // one input request as the driver presents it
  typedef struct packed {
    logic              kind;
    logic [IndexW-1:0] index;
    logic [ByteW-1:0]  value;
    logic              last_byte;
  } request_t;

  // one flag as the block returns it
  typedef struct packed {
    logic               hit;
    logic [PosOutW-1:0] pos;
    logic               last;
  } flag_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [LengthW-1:0] cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  request_t           in_req    = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic               match_flag;
  logic [PosOutW-1:0] start_position;
  logic               last_flag;

  // stimulus side
  request_t           request_q[$];
  logic [ByteW-1:0]   pat_shadow[MaxPat];   // pattern as the generator last wrote it
  int                 pushed_cnt    = 0;
  int                 accepted_cnt  = 0;
  bit                 idle_on       = 1'b1;
  bit                 rx_hold_req   = 1'b0;

  // predictor state, mirrors the block
  logic [ByteW-1:0]   pat_mem[MaxPat];
  logic [ByteW-1:0]   win[MaxPat];          // entry 0 is the newest text byte
  logic [PosOutW-1:0] seen_cnt  = '0;
  logic [PosOutW-1:0] given_cnt = '0;
  logic [LengthW-1:0] len_cfg   = '0;
  flag_t              expected_flags[$];

  int                 mismatch_cnt = 0;

  substring_occurrence_marker #(
    .MAX_PATTERN  (MaxPat),
    .POSITION_BITS(PosOutW)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .req_type_i      (in_req.kind),
    .pattern_index_i (in_req.index),
    .data_byte_i     (in_req.value),
    .text_end_i      (in_req.last_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .match_flag_o    (match_flag),
    .start_position_o(start_position),
    .last_flag_o     (last_flag)
  );

  // 2 time unit clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_window();
    for (int i = 0; i < MaxPat; i++) win[i] = '0;
  endfunction

  // pattern vs. the text start whose age (newest = 0) is age
  function automatic logic window_matches(int age, int len);
    int a;
    for (int i = 0; i < len; i++) begin
      a = age - i;
      if (a < 0 || a >= MaxPat) return 1'b0;
      if (pat_mem[i] != win[a]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void push_flag(logic hit, logic last);
    flag_t f;
    f.hit  = hit;
    f.pos  = given_cnt;
    f.last = last;
    expected_flags.push_back(f);
    given_cnt = given_cnt + 1'b1;
  endfunction

  // flags caused by one accepted request
  function automatic void predict_flags(request_t r);
    int                 eff_len;
    int                 open_cnt;
    logic [PosOutW-1:0] diff;
    logic               hit;
    // lengths above the store depth saturate
    eff_len = (len_cfg > MaxPat) ? MaxPat : len_cfg;
    if (r.kind == REQ_PATTERN) begin
      // index is 5 bits, always inside the store; text_end is ignored here
      pat_mem[r.index] = r.value;
      return;
    end
    for (int i = MaxPat - 1; i > 0; i--) win[i] = win[i-1];
    win[0]   = r.value;
    seen_cnt = seen_cnt + 1'b1;
    diff     = seen_cnt - given_cnt;
    open_cnt = diff;
    // oldest open start is complete once enough bytes are in
    if (open_cnt >= eff_len && open_cnt > 0) begin
      hit = window_matches(open_cnt - 1, eff_len);
      open_cnt--;
      push_flag(hit, r.last_byte && open_cnt == 0);
    end
    // end of text: flush the trailing starts, short ones flag zero
    if (r.last_byte) begin
      while (open_cnt > 0) begin
        hit = (open_cnt >= eff_len) ? window_matches(open_cnt - 1, eff_len) : 1'b0;
        open_cnt--;
        push_flag(hit, open_cnt == 0);
      end
      seen_cnt  = '0;
      given_cnt = '0;
      clear_window();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: request channel, fed from request_q
  // ---------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    if (rst_n && (!in_valid || !in_stall)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        in_req   <= request_q.pop_front();
        in_valid <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // prediction runs on the request actually taken at this edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predict_flags(in_req);
      accepted_cnt++;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: random bursts plus one long hold-off
  // ---------------------------------------------------------------------------
  int  stall_left    = 0;
  int  rx_hold_left  = 0;
  bit  rx_hold_taken = 1'b0;

  always @(posedge clk) begin
    if (rx_hold_req && !rx_hold_taken) begin
      rx_hold_taken = 1'b1;
      rx_hold_left  = HoldCycles;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and checker
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want,
                                 logic [31:0] pos);
    $display("mismatch @%0t start %0d: %s got %0h, expected %0h", $time, pos, what,
             got, want);
    mismatch_cnt++;
  endtask

  flag_t want_flag;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_flags.size() == 0) begin
        report_mismatch("flag with nothing pending", match_flag, 0, start_position);
      end else begin
        want_flag = expected_flags.pop_front();
        if (match_flag !== want_flag.hit)
          report_mismatch("match_flag", match_flag, want_flag.hit, want_flag.pos);
        if (start_position !== want_flag.pos)
          report_mismatch("start_position", start_position, want_flag.pos, want_flag.pos);
        if (last_flag !== want_flag.last)
          report_mismatch("last_flag", last_flag, want_flag.last, want_flag.pos);
      end
    end
  end

  // watchdog: a stretch with no transfer on any port ends the run
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_req(logic kind, int index, int value, logic last_byte);
    request_t r;
    r.kind      = kind;
    r.index     = IndexW'(index);
    r.value     = ByteW'(value);
    r.last_byte = last_byte;
    request_q.push_back(r);
    pushed_cnt++;
    if (kind == REQ_PATTERN) pat_shadow[index] = ByteW'(value);
  endtask

  // sender pause: everything taken, every flag back, then the tail latency
  task automatic wait_idle();
    while (accepted_cnt != pushed_cnt) @(negedge clk);
    while (expected_flags.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // only called while the block is idle
  task automatic write_length(int v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= LengthW'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    len_cfg = LengthW'(v);
  endtask

  // text bytes mostly drawn from the pattern alphabet so matches happen
  function automatic int pick_byte(int m);
    int top;
    top = (m > 1) ? m - 1 : 0;
    if ($urandom_range(0, 1) == 0) return pat_shadow[$urandom_range(0, top)];
    return $urandom_range(0, 255);
  endfunction

  // one text of n bytes: pattern copies (some broken), filler, rare pattern rewrites
  task automatic push_text(int n, int m);
    int p;
    int bad;
    int val;
    p = 0;
    while (p < n) begin
      if (m > 0 && n - p >= m && $urandom_range(0, 3) == 0) begin
        bad = (m > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(0, m - 1) : -1;
        for (int i = 0; i < m; i++) begin
          val = (i == bad) ? $urandom_range(0, 255) : pat_shadow[i];
          push_req(REQ_TEXT, $urandom_range(0, 31), val, p == n - 1);
          p++;
        end
      end else begin
        if ($urandom_range(0, 39) == 0)
          push_req(REQ_PATTERN, $urandom_range(0, 31), pick_byte(m),
                   1'($urandom_range(0, 1)));
        push_req(REQ_TEXT, $urandom_range(0, 31), pick_byte(m), p == n - 1);
        p++;
      end
    end
  endtask

  initial begin : stimulus
    int phase;
    int len;
    int eff;
    int rand_start;
    int sel;
    int sym_a;
    int sym_b;
    clear_window();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty pattern: every position flags one
    write_length(0);
    for (int i = 0; i < MaxPat; i++) push_req(REQ_PATTERN, i, $urandom_range(0, 255), 1'b0);
    push_req(REQ_TEXT, 0, 8'h00, 1'b0);
    push_req(REQ_TEXT, 31, 8'hFF, 1'b1);
    push_req(REQ_TEXT, 0, 8'h5A, 1'b1);
    wait_idle();

    // overlapping hits and trailing flush; text_end on a pattern write is ignored
    write_length(2);
    push_req(REQ_PATTERN, 0, 8'hAA, 1'b0);
    push_req(REQ_PATTERN, 1, 8'hAA, 1'b1);
    push_req(REQ_TEXT, 0, 8'hAA, 1'b0);
    push_req(REQ_TEXT, 0, 8'hAA, 1'b0);
    push_req(REQ_TEXT, 0, 8'hAA, 1'b0);
    push_req(REQ_TEXT, 0, 8'h55, 1'b0);
    push_req(REQ_TEXT, 0, 8'hAA, 1'b1);
    wait_idle();

    // single byte texts
    write_length(1);
    push_req(REQ_TEXT, 0, 8'hAA, 1'b1);
    push_req(REQ_TEXT, 0, 8'h00, 1'b1);
    wait_idle();

    // length above the store saturates; a short text only flushes zeros
    write_length(63);
    push_req(REQ_TEXT, 0, 8'hAA, 1'b0);
    push_req(REQ_TEXT, 0, 8'hAA, 1'b0);
    push_req(REQ_TEXT, 0, 8'hAA, 1'b0);
    push_req(REQ_TEXT, 0, 8'hAA, 1'b1);
    wait_idle();

    // pattern rewritten in the middle of a text
    write_length(3);
    push_req(REQ_PATTERN, 0, 8'h12, 1'b0);
    push_req(REQ_PATTERN, 1, 8'h34, 1'b0);
    push_req(REQ_PATTERN, 2, 8'h56, 1'b0);
    push_req(REQ_TEXT, 0, 8'h12, 1'b0);
    push_req(REQ_TEXT, 0, 8'h34, 1'b0);
    push_req(REQ_PATTERN, 2, 8'hFF, 1'b1);
    push_req(REQ_TEXT, 0, 8'h56, 1'b0);
    push_req(REQ_TEXT, 0, 8'h12, 1'b0);
    push_req(REQ_TEXT, 0, 8'h34, 1'b0);
    push_req(REQ_TEXT, 0, 8'hFF, 1'b1);

    // random phases: new length, new pattern, a few texts each
    rand_start = pushed_cnt;
    phase      = 0;
    while (pushed_cnt - rand_start < RandItems) begin
      wait_idle();
      // no idling in the last part of the run
      if (pushed_cnt - rand_start > RandItems * 5 / 6) idle_on = 1'b0;
      case (phase)
        0: len = 32;
        1: len = 0;
        2: len = 2;
        3: len = 40;
        default: begin
          sel = $urandom_range(0, 9);
          if (sel < 7) len = $urandom_range(1, 5);
          else if (sel == 7) len = 0;
          else if (sel == 8) len = $urandom_range(20, 32);
          else len = $urandom_range(33, 63);
        end
      endcase
      write_length(len);
      eff   = (len > MaxPat) ? MaxPat : len;
      sym_a = $urandom_range(0, 255);
      sym_b = $urandom_range(0, 255);
      for (int i = 0; i < eff; i++)
        push_req(REQ_PATTERN, i, $urandom_range(0, 1) ? sym_a : sym_b,
                 1'($urandom_range(0, 1)));
      // receiver goes quiet while requests keep coming, so the block backs up
      if (phase == 2) rx_hold_req = 1'b1;
      repeat ((phase == 2) ? 6 : 3) push_text($urandom_range(1, eff + 8), eff);
      phase++;
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatch_cnt == 0 && expected_flags.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
